/* hw/rtl/bracket_key_value_line_parser_unit_macros.svh */
// Assertion macros used by the bracket key/value parser checker.
`ifndef BRACKET_KEY_VALUE_LINE_PARSER_UNIT_MACROS_SVH
`define BRACKET_KEY_VALUE_LINE_PARSER_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BKVLP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BKVLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bkvlp_pkg.sv */
// Types, constants and codes shared by the bracket key/value parser modules.
`timescale 1ns / 1ps
`default_nettype none

package bkvlp_pkg;

  localparam int unsigned MAX_NAME    = 32;
  localparam int unsigned TOKEN_LIMIT = 50;
  localparam int unsigned NAME_AW     = $clog2(MAX_NAME);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;

  localparam logic [1:0] CFG_NAME_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_VALUE_LIMIT = 2'd1;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_COMMENT    = 3'd0,
    ST_BLANK      = 3'd1,
    ST_OK         = 3'd2,
    ST_NO_BRACKET = 3'd3,
    ST_BAD_NAME   = 3'd4,
    ST_NO_EQUALS  = 3'd5,
    ST_TEXT_ENDED = 3'd6
  } rec_status_e;

  typedef enum logic [3:0] {
    PH_BETWEEN         = 4'd0,
    PH_COMMENT         = 4'd1,
    PH_LEAD            = 4'd2,
    PH_NAME            = 4'd3,
    PH_BADLINE         = 4'd4,
    PH_EQUALS          = 4'd5,
    PH_VALUES          = 4'd6,
    PH_AWAIT_BLANK     = 4'd7,
    PH_AWAIT_OK        = 4'd8,
    PH_AWAIT_NOBRACKET = 4'd9,
    PH_AWAIT_BADNAME   = 4'd10,
    PH_AWAIT_NOEQ      = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    TK_LEAD   = 2'd0,
    TK_SIGN   = 2'd1,
    TK_DIGITS = 2'd2,
    TK_STOP   = 2'd3
  } tok_stage_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_PRE,
    CS_PROC,
    CS_NAME,
    CS_NFIN,
    CS_EOT,
    CS_FLUSH
  } ctrl_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_PRE,
    OP_PROC,
    OP_NAME,
    OP_NFIN,
    OP_EOT,
    OP_FLUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic can_emit;
    logic pre_done;
    logic eq_go;
    logic name_last;
    logic vlimit_zero;
  } dp_status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] payload;
    logic [15:0] position;
    logic [2:0]  status;
    logic [5:0]  name_len;
    logic [15:0] value_total;
    logic [15:0] rec_bytes;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/bkvlp_ctrl.sv */
// Sequencer that walks each accepted byte through its parse steps.
`timescale 1ns / 1ps
`default_nettype none

module bkvlp_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire bkvlp_pkg::dp_status_t status_i,
  output bkvlp_pkg::dp_cmd_t         cmd_o
);

  bkvlp_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bkvlp_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bkvlp_pkg::CS_IDLE: begin
        if (in_valid_i) state_d = bkvlp_pkg::CS_PRE;
      end
      bkvlp_pkg::CS_PRE: begin
        if (status_i.can_emit) begin
          state_d = status_i.pre_done ? bkvlp_pkg::CS_EOT : bkvlp_pkg::CS_PROC;
        end
      end
      bkvlp_pkg::CS_PROC: begin
        if (status_i.can_emit) begin
          state_d = status_i.eq_go ? bkvlp_pkg::CS_NAME : bkvlp_pkg::CS_EOT;
        end
      end
      bkvlp_pkg::CS_NAME: begin
        if (status_i.can_emit && status_i.name_last) begin
          state_d = status_i.vlimit_zero ? bkvlp_pkg::CS_NFIN : bkvlp_pkg::CS_EOT;
        end
      end
      bkvlp_pkg::CS_NFIN: begin
        if (status_i.can_emit) state_d = bkvlp_pkg::CS_EOT;
      end
      bkvlp_pkg::CS_EOT: begin
        if (status_i.can_emit) state_d = bkvlp_pkg::CS_FLUSH;
      end
      bkvlp_pkg::CS_FLUSH: begin
        if (status_i.can_emit) state_d = bkvlp_pkg::CS_IDLE;
      end
      default: state_d = bkvlp_pkg::CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op   = bkvlp_pkg::OP_NONE;
    in_stall_o = (state_q != bkvlp_pkg::CS_IDLE);
    case (state_q)
      bkvlp_pkg::CS_IDLE: begin
        if (in_valid_i) cmd_o.op = bkvlp_pkg::OP_LOAD;
      end
      bkvlp_pkg::CS_PRE: begin
        if (status_i.can_emit) cmd_o.op = bkvlp_pkg::OP_PRE;
      end
      bkvlp_pkg::CS_PROC: begin
        if (status_i.can_emit) cmd_o.op = bkvlp_pkg::OP_PROC;
      end
      bkvlp_pkg::CS_NAME: begin
        if (status_i.can_emit) cmd_o.op = bkvlp_pkg::OP_NAME;
      end
      bkvlp_pkg::CS_NFIN: begin
        if (status_i.can_emit) cmd_o.op = bkvlp_pkg::OP_NFIN;
      end
      bkvlp_pkg::CS_EOT: begin
        if (status_i.can_emit) cmd_o.op = bkvlp_pkg::OP_EOT;
      end
      bkvlp_pkg::CS_FLUSH: begin
        if (status_i.can_emit) cmd_o.op = bkvlp_pkg::OP_FLUSH;
      end
      default: cmd_o.op = bkvlp_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/bkvlp_datapath.sv */
// Parse state, name memory, token converter and result staging.
`timescale 1ns / 1ps
`default_nettype none

module bkvlp_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bkvlp_pkg::dp_cmd_t   cmd_i,
  output bkvlp_pkg::dp_status_t     status_o,
  input  wire logic [7:0]           text_byte_i,
  input  wire logic                 end_of_text_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [15:0]          cfg_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output bkvlp_pkg::result_t        out_res_o,
  output logic                      out_last_o
);

  localparam int unsigned NAW = bkvlp_pkg::NAME_AW;

  logic [5:0]  name_limit_q;
  logic [15:0] value_limit_q;

  logic [7:0]  byte_q;
  logic        eot_q;

  bkvlp_pkg::phase_e phase_q, phase_d;
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  trim_q, trim_d;
  logic [31:0] acc_q, acc_d;
  logic [5:0]  tbytes_q, tbytes_d;
  logic [2:0]  tflags_q, tflags_d;
  logic [15:0] vdone_q, vdone_d;
  logic [15:0] bc_q, bc_d;
  logic        pcr_q, pcr_d;
  logic [5:0]  k_q, k_d;

  logic [7:0]  name_mem [bkvlp_pkg::MAX_NAME];
  logic [7:0]  rd_q;
  logic        mem_we;
  logic [NAW-1:0] mem_wa;

  bkvlp_pkg::result_t pend_q, pend_d, res;
  logic        pend_v_q, pend_v_d;
  bkvlp_pkg::result_t out_q;
  logic        out_v_q, out_v_d, out_last_q;

  logic        prod, clr, out_free, can_emit, push_out;
  logic [15:0] bc_inc;
  logic        is_await, is_sep, is_digit;
  logic [5:0]  lim;
  logic [34:0] acc_mul;
  logic [31:0] tok_val;
  logic [15:0] vd_new;
  logic [1:0]  tst;
  logic [2:0]  fin_st;

  function automatic bkvlp_pkg::result_t mk_finish(logic [2:0] st, logic [5:0] trim,
                                                   logic [15:0] vd, logic [15:0] bc);
    bkvlp_pkg::result_t r;
    r.kind        = bkvlp_pkg::KIND_FINISH;
    r.payload     = '0;
    r.position    = '0;
    r.status      = st;
    r.name_len    = (st == bkvlp_pkg::ST_OK) ? trim : 6'd0;
    r.value_total = vd;
    r.rec_bytes   = bc;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_limit_q  <= 6'd33;
      value_limit_q <= 16'd16;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == bkvlp_pkg::CFG_NAME_LIMIT) name_limit_q <= cfg_data_i[5:0];
      else if (cfg_index_i == bkvlp_pkg::CFG_VALUE_LIMIT) value_limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == bkvlp_pkg::OP_LOAD) begin
      byte_q <= text_byte_i;
      eot_q  <= end_of_text_i;
    end
    if (mem_we) name_mem[mem_wa] <= byte_q;
    rd_q <= name_mem[k_d[NAW-1:0]];
    pend_q <= pend_d;
    if (push_out) begin
      out_q      <= pend_q;
      out_last_q <= (cmd_i.op == bkvlp_pkg::OP_FLUSH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= bkvlp_pkg::PH_BETWEEN;
      fill_q   <= '0;
      trim_q   <= '0;
      acc_q    <= '0;
      tbytes_q <= '0;
      tflags_q <= '0;
      vdone_q  <= '0;
      bc_q     <= '0;
      pcr_q    <= 1'b0;
      k_q      <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fill_q   <= fill_d;
      trim_q   <= trim_d;
      acc_q    <= acc_d;
      tbytes_q <= tbytes_d;
      tflags_q <= tflags_d;
      vdone_q  <= vdone_d;
      bc_q     <= bc_d;
      pcr_q    <= pcr_d;
      k_q      <= k_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  assign bc_inc   = (bc_q == 16'hFFFF) ? bc_q : bc_q + 16'd1;
  assign is_await = (phase_q >= bkvlp_pkg::PH_AWAIT_BLANK) &&
                    (phase_q <= bkvlp_pkg::PH_AWAIT_NOEQ);
  assign is_sep   = (byte_q == bkvlp_pkg::CH_CR) || (byte_q == bkvlp_pkg::CH_SPACE) ||
                    (byte_q == bkvlp_pkg::CH_TAB);
  assign is_digit = (byte_q >= bkvlp_pkg::CH_ZERO) && (byte_q <= bkvlp_pkg::CH_NINE);
  assign lim      = (name_limit_q > 6'(bkvlp_pkg::MAX_NAME + 1)) ?
                    6'(bkvlp_pkg::MAX_NAME + 1) : name_limit_q;
  assign acc_mul  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {31'd0, byte_q[3:0]};
  assign tok_val  = tflags_q[2] ? (32'd0 - acc_q) :
                    (acc_q > 32'h7FFF_FFFF ? 32'h7FFF_FFFF : acc_q);

  assign out_free = !out_v_q || !out_stall_i;
  assign can_emit = !pend_v_q || out_free;

  always_comb begin
    phase_d  = phase_q;
    fill_d   = fill_q;
    trim_d   = trim_q;
    acc_d    = acc_q;
    tbytes_d = tbytes_q;
    tflags_d = tflags_q;
    vdone_d  = vdone_q;
    bc_d     = bc_q;
    pcr_d    = pcr_q;
    k_d      = k_q;
    mem_we   = 1'b0;
    mem_wa   = fill_q[NAW-1:0];
    prod     = 1'b0;
    clr      = 1'b0;
    res      = mk_finish(bkvlp_pkg::ST_OK, trim_q, vdone_q, bc_q);
    vd_new   = vdone_q;
    tst      = tflags_q[1:0];
    fin_st   = bkvlp_pkg::ST_TEXT_ENDED;

    case (cmd_i.op)
      bkvlp_pkg::OP_PRE: begin
        if (is_await) begin
          prod = 1'b1;
          clr  = 1'b1;
          res  = mk_finish(3'(phase_q - 4'd6), trim_q, vdone_q,
                           (byte_q == bkvlp_pkg::CH_LF) ? bc_inc : bc_q);
        end
      end
      bkvlp_pkg::OP_PROC: begin
        bc_d = bc_inc;
        k_d  = '0;
        case (phase_q)
          bkvlp_pkg::PH_BETWEEN: begin
            if (byte_q == bkvlp_pkg::CH_HASH) begin
              phase_d = bkvlp_pkg::PH_COMMENT;
              pcr_d   = 1'b0;
            end else if (byte_q == bkvlp_pkg::CH_CR) begin
              phase_d = bkvlp_pkg::PH_AWAIT_BLANK;
            end else if (byte_q == bkvlp_pkg::CH_LBR) begin
              phase_d = bkvlp_pkg::PH_LEAD;
            end
          end
          bkvlp_pkg::PH_COMMENT: begin
            if (pcr_q && byte_q == bkvlp_pkg::CH_LF) begin
              prod = 1'b1;
              clr  = 1'b1;
              res  = mk_finish(bkvlp_pkg::ST_COMMENT, trim_q, vdone_q, bc_inc);
            end else begin
              pcr_d = (byte_q == bkvlp_pkg::CH_CR);
            end
          end
          bkvlp_pkg::PH_LEAD, bkvlp_pkg::PH_NAME: begin
            if (phase_q == bkvlp_pkg::PH_LEAD &&
                (byte_q == bkvlp_pkg::CH_LBR || byte_q == bkvlp_pkg::CH_SPACE)) begin
              phase_d = phase_q;
            end else if (byte_q == bkvlp_pkg::CH_RBR) begin
              phase_d = (trim_q == 6'd0 || trim_q >= lim) ? bkvlp_pkg::PH_BADLINE
                                                          : bkvlp_pkg::PH_EQUALS;
            end else if (byte_q == bkvlp_pkg::CH_CR) begin
              phase_d = bkvlp_pkg::PH_AWAIT_NOBRACKET;
            end else begin
              phase_d = bkvlp_pkg::PH_NAME;
              mem_we  = (fill_q < 6'(bkvlp_pkg::MAX_NAME));
              if (fill_q <= 6'(bkvlp_pkg::MAX_NAME)) fill_d = fill_q + 6'd1;
              if (byte_q != bkvlp_pkg::CH_SPACE) trim_d = fill_d;
            end
          end
          bkvlp_pkg::PH_BADLINE: begin
            if (byte_q == bkvlp_pkg::CH_CR) phase_d = bkvlp_pkg::PH_AWAIT_BADNAME;
          end
          bkvlp_pkg::PH_EQUALS: begin
            if (byte_q == bkvlp_pkg::CH_CR) phase_d = bkvlp_pkg::PH_AWAIT_NOEQ;
          end
          bkvlp_pkg::PH_VALUES: begin
            if (pcr_q && byte_q == bkvlp_pkg::CH_LF) begin
              prod = 1'b1;
              clr  = 1'b1;
              res  = mk_finish(bkvlp_pkg::ST_OK, trim_q, vdone_q, bc_inc);
            end else if (is_sep) begin
              pcr_d = 1'b0;
              if (tbytes_q != 6'd0 && tbytes_q < 6'(bkvlp_pkg::TOKEN_LIMIT)) begin
                prod             = 1'b1;
                vd_new           = vdone_q + 16'd1;
                res.kind         = bkvlp_pkg::KIND_VALUE;
                res.payload      = tok_val[15:0];
                res.position     = vdone_q;
                res.status       = bkvlp_pkg::ST_OK;
                res.name_len     = trim_q;
                res.value_total  = vd_new;
                res.rec_bytes    = bc_inc;
              end
              vdone_d  = vd_new;
              acc_d    = '0;
              tbytes_d = '0;
              tflags_d = '0;
              if (vd_new >= value_limit_q) phase_d = bkvlp_pkg::PH_AWAIT_OK;
              else pcr_d = 1'b1;
            end else begin
              pcr_d = 1'b0;
              if (tbytes_q < 6'(bkvlp_pkg::TOKEN_LIMIT)) tbytes_d = tbytes_q + 6'd1;
              if (tst == bkvlp_pkg::TK_LEAD) begin
                if (byte_q == bkvlp_pkg::CH_LF || byte_q == bkvlp_pkg::CH_VT ||
                    byte_q == bkvlp_pkg::CH_FF) begin
                  tst = bkvlp_pkg::TK_LEAD;
                end else if (byte_q == bkvlp_pkg::CH_PLUS ||
                             byte_q == bkvlp_pkg::CH_MINUS) begin
                  tflags_d = {byte_q == bkvlp_pkg::CH_MINUS, bkvlp_pkg::TK_SIGN};
                end else begin
                  tst = bkvlp_pkg::TK_SIGN;
                end
              end
              if (tst == bkvlp_pkg::TK_SIGN || tst == bkvlp_pkg::TK_DIGITS) begin
                if (is_digit) begin
                  acc_d = (acc_mul > 35'h0_8000_0000) ? 32'h8000_0000 : acc_mul[31:0];
                  tflags_d = {tflags_q[2], bkvlp_pkg::TK_DIGITS};
                end else begin
                  tflags_d = {tflags_q[2], bkvlp_pkg::TK_STOP};
                end
              end
            end
          end
          default: clr = 1'b1;
        endcase
      end
      bkvlp_pkg::OP_NAME: begin
        prod            = 1'b1;
        res.kind        = bkvlp_pkg::KIND_NAME;
        res.payload     = {8'd0, rd_q};
        res.position    = {10'd0, k_q};
        res.status      = bkvlp_pkg::ST_OK;
        res.name_len    = trim_q;
        res.value_total = '0;
        res.rec_bytes   = bc_q;
        k_d             = k_q + 6'd1;
        // enter the value part once the last name byte goes out, unless value_limit is zero
        if (k_d == trim_q && value_limit_q != 16'd0) begin
          phase_d  = bkvlp_pkg::PH_VALUES;
          acc_d    = '0;
          tbytes_d = '0;
          tflags_d = '0;
          pcr_d    = 1'b0;
        end
      end
      bkvlp_pkg::OP_NFIN: begin
        prod = 1'b1;
        clr  = 1'b1;
        res  = mk_finish(bkvlp_pkg::ST_OK, trim_q, vdone_q, bc_q);
      end
      bkvlp_pkg::OP_EOT: begin
        if (phase_q == bkvlp_pkg::PH_VALUES) fin_st = bkvlp_pkg::ST_OK;
        else if (phase_q == bkvlp_pkg::PH_BADLINE) fin_st = bkvlp_pkg::ST_BAD_NAME;
        else if (is_await) fin_st = 3'(phase_q - 4'd6);
        if (eot_q && (phase_q != bkvlp_pkg::PH_BETWEEN || bc_q != 16'd0)) begin
          prod = 1'b1;
          res  = mk_finish(fin_st, trim_q, vdone_q, bc_q);
        end
        clr = eot_q;
      end
      default: begin
      end
    endcase

    if (clr) begin
      phase_d  = bkvlp_pkg::PH_BETWEEN;
      fill_d   = '0;
      trim_d   = '0;
      acc_d    = '0;
      tbytes_d = '0;
      tflags_d = '0;
      vdone_d  = '0;
      bc_d     = '0;
      pcr_d    = 1'b0;
    end
  end

  // stage each result one step so the last one of a byte can be marked
  always_comb begin
    push_out = pend_v_q && (prod || cmd_i.op == bkvlp_pkg::OP_FLUSH);
    pend_d   = prod ? res : pend_q;
    pend_v_d = prod ? 1'b1 : (cmd_i.op == bkvlp_pkg::OP_FLUSH ? 1'b0 : pend_v_q);
    if (push_out) out_v_d = 1'b1;
    else if (out_v_q && !out_stall_i) out_v_d = 1'b0;
    else out_v_d = out_v_q;
  end

  assign status_o.can_emit    = can_emit;
  assign status_o.pre_done    = is_await && (byte_q == bkvlp_pkg::CH_LF);
  assign status_o.eq_go       = (phase_q == bkvlp_pkg::PH_EQUALS) &&
                                (byte_q == bkvlp_pkg::CH_EQ);
  assign status_o.name_last   = ((k_q + 6'd1) == trim_q);
  assign status_o.vlimit_zero = (value_limit_q == 16'd0);

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

/* hw/rtl/bracket_key_value_line_parser_unit.sv */
// Top level of the bracket key/value settings parser.
//
//  channel | direction | handshake                 | payload
//  in      | into      | in_valid_i / in_stall_o   | text_byte_i, end_of_text_i
//  out     | out of    | out_valid_o / out_stall_i | kind_o .. run_last_o
//  cfg     | into      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte at a time: each byte goes through accept, leftover-record finish,
// parse, text-end finish and final flush; an LF that closes a record waiting
// for it skips the parse step. An '=' after an accepted name adds a name step
// per name character, and a name-finish step when value_limit is zero.
// Each step after accept waits while an earlier result of the byte is staged
// behind a stalled output. Reset clears the parse state; the name memory
// needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module bracket_key_value_line_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [15:0]      payload_o,
  output logic [15:0]      position_o,
  output logic [2:0]       record_status_o,
  output logic [5:0]       name_length_o,
  output logic [15:0]      value_total_o,
  output logic [15:0]      record_bytes_o,
  output logic             run_last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  bkvlp_pkg::dp_cmd_t    cmd;
  bkvlp_pkg::dp_status_t status;
  bkvlp_pkg::result_t    res;

  assign cfg_ready_o = 1'b1;

  bkvlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bkvlp_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_res_o     (res),
    .out_last_o    (run_last_o)
  );

  assign kind_o          = res.kind;
  assign payload_o       = res.payload;
  assign position_o      = res.position;
  assign record_status_o = res.status;
  assign name_length_o   = res.name_len;
  assign value_total_o   = res.value_total;
  assign record_bytes_o  = res.rec_bytes;

endmodule

`default_nettype wire

/* hw/rtl/bkvlp_checker.sv */
// Port-level checks for the bracket key/value parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "bracket_key_value_line_parser_unit_macros.svh"

module bkvlp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  kind_o,
  input wire logic [15:0] payload_o,
  input wire logic [15:0] position_o,
  input wire logic [2:0]  record_status_o,
  input wire logic [15:0] value_total_o
);

  `BKVLP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(payload_o) && $stable(kind_o), "stalled item changed")
  `BKVLP_ASSERT_IMPL(a_kind_code, out_valid_o, kind_o <= bkvlp_pkg::KIND_FINISH, "undefined kind")
  `BKVLP_ASSERT_IMPL(a_fin_zero, out_valid_o && kind_o == bkvlp_pkg::KIND_FINISH, payload_o == 16'd0 && position_o == 16'd0, "finish item carries data")
  `BKVLP_ASSERT_IMPL(a_body_ok, out_valid_o && kind_o != bkvlp_pkg::KIND_FINISH, record_status_o == bkvlp_pkg::ST_OK, "name or value item not ok")
  `BKVLP_ASSERT_IMPL(a_name_vtot, out_valid_o && kind_o == bkvlp_pkg::KIND_NAME, value_total_o == 16'd0, "name item counts values")

endmodule

bind bracket_key_value_line_parser_unit bkvlp_checker u_bkvlp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .kind_o          (kind_o),
  .payload_o       (payload_o),
  .position_o      (position_o),
  .record_status_o (record_status_o),
  .value_total_o   (value_total_o)
);

`default_nettype wire
